### sv/lru_cache_key_value_store_core_macros.svh
// Assertion helpers for the core RTL; every use samples on clk and
// is held off while arst_n is low.
`ifndef LRU_CACHE_KEY_VALUE_STORE_CORE_MACROS_SVH
`define LRU_CACHE_KEY_VALUE_STORE_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define LRU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LRU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/lru_pkg.sv
package lru_pkg;
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
	localparam int MAX_ENTRIES_DEF = 16;
	localparam logic [VAL_W-1:0] MISS_VALUE = '1;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	localparam int S_TDATA_W = 64;
	localparam int M_TDATA_W = 72;
	localparam int M_FIELDS_W = 1 + VAL_W + 1 + KEY_W;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} entry_t;

	typedef struct packed {
		logic             compare;
		logic             load;
		logic [KEY_W-1:0] key;
	} cell_cmd_t;
endpackage

### sv/lru_cache_key_value_store_core.sv
// Each item passes through the compare, select and shift steps that the cell row
// takes in turn; a new item is taken only as the shift step completes the last one,
// and a waiting result stalls the shift step.
// Reset: all entries invalid, count zero, capacity 16; no clearing pass.
`include "lru_cache_key_value_store_core_macros.svh"

module lru_cache_key_value_store_core import lru_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CAP_W-1:0]     cfg_wdata,      // capacity
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,        // key [31:0], write_value [63:32]
	input  logic                 s_tuser,        // func
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata         // hit, read_value, evicted, evicted_key
);
	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int EXT_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOOK = 2'd1;
	localparam logic [1:0] ST_SEL  = 2'd2;
	localparam logic [1:0] ST_UPD  = 2'd3;

	logic [1:0]       state_q;
	logic [CAP_W-1:0] capacity_q;
	logic [CNT_W-1:0] cnt_q;
	logic             op_func_q;
	logic [KEY_W-1:0] op_key_q;
	logic [VAL_W-1:0] op_val_q;

	logic             out_valid_q;
	logic             out_hit_q;
	logic [VAL_W-1:0] out_rd_q;
	logic             out_ev_q;
	logic [KEY_W-1:0] out_evk_q;

	logic                   accept;
	logic                   out_free;
	logic                   finishing;
	logic                   is_put;
	logic                   full;
	logic                   do_shift;
	logic                   evict;
	logic [IDX_W-1:0]       shift_lim;
	entry_t                 new_entry;
	cell_cmd_t              cmd;
	entry_t                 entries [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] match_vec;
	logic [MAX_ENTRIES-1:0] last_vec;
	logic [MAX_ENTRIES-1:0] valid_vec;

	logic             hit_s2;
	logic [IDX_W-1:0] hit_idx_s2;
	logic [VAL_W-1:0] hit_value_s2;
	logic [KEY_W-1:0] last_key_s2;

	assign out_free  = !out_valid_q || m_tready;
	assign finishing = (state_q == ST_UPD) && out_free;
	assign s_tready  = (state_q == ST_IDLE) || finishing;
	assign accept    = s_tvalid && s_tready;

	assign is_put = (op_func_q == OP_PUT);
	assign full   = ((EXT_W'(cnt_q) >= EXT_W'(capacity_q)) && (cnt_q != '0))
			|| (cnt_q == CNT_W'(MAX_ENTRIES));
	assign do_shift = hit_s2 || is_put;
	assign evict    = is_put && !hit_s2 && full;

	always_comb begin
		if (hit_s2) begin
			shift_lim = hit_idx_s2;
		end else if (full) begin
			shift_lim = IDX_W'(cnt_q - 1'b1);
		end else begin
			shift_lim = IDX_W'(cnt_q);
		end
	end

	assign new_entry = '{valid: 1'b1, key: op_key_q,
			value: is_put ? op_val_q : hit_value_s2};

	assign cmd = '{compare: (state_q == ST_LOOK), load: finishing && do_shift,
			key: op_key_q};

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		entry_t prev_entry;
		logic   next_valid;

		if (i == 0) begin : g_head
			assign prev_entry = new_entry;
		end else begin : g_body
			assign prev_entry = entries[i-1];
		end

		if (i == MAX_ENTRIES - 1) begin : g_tail
			assign next_valid = 1'b0;
		end else begin : g_mid
			assign next_valid = entries[i+1].valid;
		end

		lru_cell #(
			.IDX   (i),
			.IDX_W (IDX_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.shift_lim  (shift_lim),
			.prev       (prev_entry),
			.next_valid (next_valid),
			.entry      (entries[i]),
			.match      (match_vec[i]),
			.last       (last_vec[i])
		);

		assign valid_vec[i] = entries[i].valid;
	end

	lru_sel #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.IDX_W       (IDX_W)
	) u_sel (
		.clk          (clk),
		.arst_n       (arst_n),
		.match_vec    (match_vec),
		.last_vec     (last_vec),
		.entries      (entries),
		.hit_s2       (hit_s2),
		.hit_idx_s2   (hit_idx_s2),
		.hit_value_s2 (hit_value_s2),
		.last_key_s2  (last_key_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			capacity_q  <= CAP_RESET;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: state_q <= ST_SEL;
				ST_SEL:  state_q <= ST_UPD;
				ST_UPD: begin
					if (accept) begin
						state_q <= ST_LOOK;
					end else if (finishing) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// an insert below the limit grows the row; an eviction keeps the count
			if (finishing && is_put && !hit_s2 && !full) begin
				cnt_q <= cnt_q + 1'b1;
			end

			if (finishing) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_func_q <= s_tuser;
			op_key_q  <= s_tdata[KEY_W-1:0];
			op_val_q  <= s_tdata[KEY_W +: VAL_W];
		end
		if (finishing) begin
			out_hit_q <= hit_s2;
			if (is_put) begin
				out_rd_q <= '0;
			end else if (hit_s2) begin
				out_rd_q <= hit_value_s2;
			end else begin
				out_rd_q <= MISS_VALUE;
			end
			out_ev_q  <= evict;
			out_evk_q <= evict ? last_key_s2 : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(M_TDATA_W - M_FIELDS_W){1'b0}}, out_evk_q, out_ev_q, out_rd_q,
			out_hit_q};

	`LRU_ASSERT_NOW(a_key_unique, state_q == ST_UPD, $onehot0(match_vec), "key in two cells")
	`LRU_ASSERT_NOW(a_cnt_valid, 1'b1, $countones(valid_vec) == cnt_q, "count mismatch")
	`LRU_ASSERT_NOW(a_hit_no_evict, out_valid_q && out_hit_q, !out_ev_q, "hit evicted")
	`LRU_ASSERT_NEXT(a_done_idle, finishing && !accept, state_q == ST_IDLE, "not idle")
endmodule

### sv/lru_cell.sv
module lru_cell import lru_pkg::*; #(
	parameter int IDX   = 0,
	parameter int IDX_W = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_cmd_t        cmd,
	input  logic [IDX_W-1:0] shift_lim,
	input  entry_t           prev,
	input  logic             next_valid,
	output entry_t           entry,
	output logic             match,
	output logic             last
);
	logic             valid_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;
	logic             match_q;
	logic             shift_en;

	// take the neighbour's entry when this cell lies at or below the limit
	assign shift_en = cmd.load && (IDX_W'(IDX) <= shift_lim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (cmd.compare) begin
				match_q <= valid_q && (key_q == cmd.key);
			end
			if (shift_en) begin
				valid_q <= prev.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			key_q   <= prev.key;
			value_q <= prev.value;
		end
	end

	assign entry = '{valid: valid_q, key: key_q, value: value_q};
	assign match = match_q;
	// valid entries are packed from cell 0, so the last one has no valid successor
	assign last  = valid_q && !next_valid;
endmodule

### sv/lru_sel.sv
module lru_sel import lru_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	parameter int IDX_W       = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [MAX_ENTRIES-1:0] match_vec,
	input  logic [MAX_ENTRIES-1:0] last_vec,
	input  entry_t                 entries [MAX_ENTRIES],
	output logic                   hit_s2,
	output logic [IDX_W-1:0]       hit_idx_s2,
	output logic [VAL_W-1:0]       hit_value_s2,
	output logic [KEY_W-1:0]       last_key_s2
);
	logic [IDX_W-1:0] idx_d;
	logic [VAL_W-1:0] value_d;
	logic [KEY_W-1:0] key_d;

	// match and last each have at most one bit set, so an and-or merge picks the single entry
	always_comb begin
		idx_d   = '0;
		value_d = '0;
		key_d   = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (match_vec[i]) begin
				idx_d = idx_d | IDX_W'(i);
			end
			value_d = value_d | (entries[i].value & {VAL_W{match_vec[i]}});
			key_d   = key_d | (entries[i].key & {KEY_W{last_vec[i]}});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s2 <= 1'b0;
		end else begin
			hit_s2 <= |match_vec;
		end
	end

	always_ff @(posedge clk) begin
		hit_idx_s2   <= idx_d;
		hit_value_s2 <= value_d;
		last_key_s2  <= key_d;
	end
endmodule

### tb/lru_cache_key_value_store_core_tb.sv
`timescale 1ns / 1ps

module lru_cache_key_value_store_core_tb;
	import lru_pkg::*;

	localparam int NUM_SLOTS  = MAX_ENTRIES_DEF;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 8;
	localparam int MAX_PRINTS  = 40;

	typedef struct packed {
		logic             hit;
		logic [VAL_W-1:0] read_value;
		logic             evicted;
		logic [KEY_W-1:0] evicted_key;
	} cache_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CAP_W-1:0]     cfg_wdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 s_tuser = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	lru_cache_key_value_store_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// shadow copy of the store
	logic             shadow_valid [NUM_SLOTS];
	logic [KEY_W-1:0] shadow_key   [NUM_SLOTS];
	logic [VAL_W-1:0] shadow_value [NUM_SLOTS];
	logic [3:0]       shadow_rank  [NUM_SLOTS];
	logic [CAP_W:0]   shadow_count;
	logic [CAP_W-1:0] shadow_capacity;

	cache_result_t pending_results[$];

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int rx_hold_cycles = 0;
	int mismatches = 0;
	int items_sent = 0;
	int results_seen = 0;
	int hits_seen = 0;
	int evictions_seen = 0;
	int capacity_writes = 0;
	int stall_cycles = 0;

	logic [KEY_W-1:0] key_pool[32];
	int               pool_size = 1;

	always #5 clk = ~clk;

	function automatic int effective_capacity();
		if (shadow_capacity == '0)
			return 1;
		if (shadow_capacity > NUM_SLOTS)
			return NUM_SLOTS;
		return int'(shadow_capacity);
	endfunction

	// move slot s to the front; everything more recent than it ages by one
	function automatic void promote_slot(int s);
		logic [3:0] old_rank;
		old_rank = shadow_rank[s];
		for (int i = 0; i < NUM_SLOTS; i++)
			if (shadow_valid[i] && i != s && shadow_rank[i] < old_rank)
				shadow_rank[i]++;
		shadow_rank[s] = '0;
	endfunction

	function automatic cache_result_t cache_access(logic op, logic [KEY_W-1:0] k,
			logic [VAL_W-1:0] v);
		cache_result_t r;
		int            found_slot;
		int            slot;
		logic [3:0]    oldest;
		bit            seen;
		r = '0;
		found_slot = -1;
		for (int i = 0; i < NUM_SLOTS; i++)
			if (found_slot < 0 && shadow_valid[i] && shadow_key[i] == k)
				found_slot = i;
		if (op == OP_GET) begin
			if (found_slot >= 0) begin
				r.hit = 1'b1;
				r.read_value = shadow_value[found_slot];
				promote_slot(found_slot);
			end else begin
				r.read_value = MISS_VALUE;
			end
		end else if (found_slot >= 0) begin
			r.hit = 1'b1;
			shadow_value[found_slot] = v;
			promote_slot(found_slot);
		end else begin
			slot = 0;
			seen = 1'b0;
			oldest = '0;
			if (int'(shadow_count) >= effective_capacity()) begin
				for (int i = 0; i < NUM_SLOTS; i++)
					if (shadow_valid[i] && (!seen || shadow_rank[i] > oldest)) begin
						oldest = shadow_rank[i];
						slot = i;
						seen = 1'b1;
					end
				r.evicted = 1'b1;
				r.evicted_key = shadow_key[slot];
				shadow_valid[slot] = 1'b0;
			end else begin
				for (int i = 0; i < NUM_SLOTS; i++)
					if (!seen && !shadow_valid[i]) begin
						slot = i;
						seen = 1'b1;
					end
				shadow_count++;
			end
			for (int i = 0; i < NUM_SLOTS; i++)
				if (shadow_valid[i])
					shadow_rank[i]++;
			shadow_valid[slot] = 1'b1;
			shadow_key[slot] = k;
			shadow_value[slot] = v;
			shadow_rank[slot] = '0;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("%0t: result %0d %s got %h want %h", $realtime, results_seen, what, got,
				want);
	endtask

	// called and returning at a falling edge; tvalid stays high on return
	task automatic send_item(logic op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
		cache_result_t r;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {v, k};
		do
			@(posedge clk);
		while (!s_tready);
		r = cache_access(op, k, v);
		pending_results.push_back(r);
		items_sent++;
		if (r.hit)
			hits_seen++;
		if (r.evicted)
			evictions_seen++;
		@(negedge clk);
	endtask

	// drop tvalid and hold until every expected result has been taken
	task automatic wait_drain();
		s_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (pending_results.size() != 0);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] cap);
		wait_drain();
		cfg_we <= 1'b1;
		cfg_wdata <= cap;
		@(negedge clk);
		cfg_we <= 1'b0;
		shadow_capacity = cap;
		capacity_writes++;
	endtask

	always @(negedge clk) begin
		if (rx_hold_cycles > 0) begin
			m_tready <= 1'b0;
			rx_hold_cycles--;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		cache_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected transfer, key", m_tdata[65:34], '0);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[0] !== want.hit)
					report_mismatch("hit", KEY_W'(m_tdata[0]), KEY_W'(want.hit));
				if (m_tdata[32:1] !== want.read_value)
					report_mismatch("read_value", m_tdata[32:1], want.read_value);
				if (m_tdata[33] !== want.evicted)
					report_mismatch("evicted", KEY_W'(m_tdata[33]), KEY_W'(want.evicted));
				if (m_tdata[65:34] !== want.evicted_key)
					report_mismatch("evicted_key", m_tdata[65:34], want.evicted_key);
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d results outstanding", $realtime,
					STALL_LIMIT, pending_results.size());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic test_lookup_and_update();
		send_item(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
		send_item(OP_PUT, 32'h0000_0000, 32'h8000_0000);
		send_item(OP_PUT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		send_item(OP_GET, 32'h0000_0000, 32'h0000_0000);
		send_item(OP_GET, 32'hFFFF_FFFF, 32'h1234_5678);
		send_item(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
		send_item(OP_GET, 32'h0000_0000, 32'h5A5A_A5A5);
		send_item(OP_GET, 32'h1234_5678, 32'h0000_0000);
		wait_drain();
	endtask

	task automatic test_eviction_order();
		write_capacity(CAP_W'(2));
		send_item(OP_PUT, 32'h0000_0011, 32'h0000_0001);
		send_item(OP_PUT, 32'h0000_0022, 32'h0000_0002);
		send_item(OP_GET, 32'h0000_0011, 32'h0000_0000);
		send_item(OP_PUT, 32'h0000_0033, 32'h0000_0003);
		send_item(OP_GET, 32'h0000_0022, 32'h0000_0000);
		send_item(OP_PUT, 32'h0000_0044, 32'h0000_0004);
		wait_drain();
	endtask

	task automatic test_capacity_limits();
		// zero behaves as one
		write_capacity(CAP_W'(0));
		send_item(OP_PUT, 32'h0000_0055, 32'hCAFE_0055);
		send_item(OP_PUT, 32'h0000_0066, 32'hCAFE_0066);
		// above the entry count saturates: once all slots are in use each new key evicts
		write_capacity(CAP_W'(31));
		for (int i = 0; i < NUM_SLOTS + 1; i++)
			send_item(OP_PUT, 32'hA500_0000 | i, $urandom);
		// lowered below the count: each miss still evicts exactly one
		write_capacity(CAP_W'(3));
		send_item(OP_PUT, 32'h0BAD_0001, 32'h0000_0001);
		send_item(OP_PUT, 32'h0BAD_0002, 32'h0000_0002);
		send_item(OP_GET, 32'hA500_0008, 32'h0000_0000);
		wait_drain();
		write_capacity(CAP_W'(16));
	endtask

	task automatic refill_key_pool();
		pool_size = $urandom_range(1, 24);
		for (int i = 0; i < 32; i++)
			if ($urandom_range(0, 1) == 1)
				key_pool[i] = $urandom;
	endtask

	task automatic test_random_traffic(int n_items, int tx_pct, int rx_pct);
		logic [KEY_W-1:0] k;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		for (int n = 0; n < n_items; n++) begin
			if (n % 60 == 0) begin
				if ($urandom_range(0, 3) == 0)
					write_capacity($urandom_range(0, 1) ? CAP_W'(1) : CAP_W'(16));
				else
					write_capacity(CAP_W'($urandom_range(0, 31)));
				refill_key_pool();
			end
			if ($urandom_range(0, 15) == 0)
				k = $urandom;
			else
				k = key_pool[$urandom_range(0, pool_size - 1)];
			send_item($urandom_range(0, 1) ? OP_PUT : OP_GET, k, $urandom);
		end
		wait_drain();
	endtask

	task automatic test_output_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		refill_key_pool();
		// receiver holds off while the sender keeps offering, filling the pipe
		rx_hold_cycles = 150;
		for (int n = 0; n < 30; n++)
			send_item($urandom_range(0, 1) ? OP_PUT : OP_GET,
				key_pool[$urandom_range(0, pool_size - 1)], $urandom);
		wait_drain();
		for (int n = 0; n < 10; n++)
			send_item($urandom_range(0, 1) ? OP_PUT : OP_GET,
				key_pool[$urandom_range(0, pool_size - 1)], $urandom);
		wait_drain();
	endtask

	initial begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			shadow_valid[i] = 1'b0;
			shadow_key[i] = '0;
			shadow_value[i] = '0;
			shadow_rank[i] = '0;
		end
		for (int i = 0; i < 32; i++)
			key_pool[i] = $urandom;
		shadow_count = '0;
		shadow_capacity = CAP_RESET;
		tx_idle_pct = 20;
		rx_idle_pct = 20;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_lookup_and_update();
		test_eviction_order();
		test_capacity_limits();
		test_random_traffic(300, 7, 76);
		test_random_traffic(300, 76, 7);
		test_random_traffic(300, 0, 0);
		test_output_backpressure();

		wait_drain();
		$display("Covered %0d gets and puts (%0d hits, %0d evictions)", items_sent,
			hits_seen, evictions_seen);
		$display("over %0d capacity settings, idle input, stalled output and a long hold-off.",
			capacity_writes);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
